// ===== sv/vtnr_pkg.sv =====
// Package for the voxel threshold neighbour replacement block.
// Holds the beat structs and fixed widths; used by every module.
`default_nettype none
package vtnr_pkg;
  localparam int ValueW = 32;
  localparam int CountW = 22;
  localparam int DirW = 3;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_MODE      = 3'd1,
    REG_DIM_X     = 3'd2,
    REG_DIM_Y     = 3'd3,
    REG_DIM_Z     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    DIR_NONE = 3'd0, DIR_MZ = 3'd1, DIR_MY = 3'd2, DIR_MX = 3'd3,
    DIR_PX = 3'd4, DIR_PY = 3'd5, DIR_PZ = 3'd6
  } dir_t;

  typedef struct packed {
    logic              req_type;
    logic [ValueW-1:0] voxel_value;
  } in_beat_t;

  typedef struct packed {
    logic [ValueW-1:0] new_value;
    logic [DirW-1:0]   source_dir;
    logic              was_flagged;
    logic [CountW-1:0] flagged_count;
    logic              last_voxel;
  } out_beat_t;
endpackage
`default_nettype wire

// ===== sv/voxel_threshold_neighbor_replace.sv =====
// Top level of the voxel threshold neighbour replacement block.
// A centre's result passes the stage 1 read registers, the selection register and the output register.
// Throughput: one beat per cycle while the output is not stalled and the sizes have settled;
// each input beat releases at most one result. After reset and after any dimension write
// the input is held off while the registered plane and volume sizes settle.
// Reset (rst, synchronous): counters and valids clear, registers take reset values.
// The window store has no reset; reads that fall outside the volume are masked by the edge flags.
// Depends on vtnr_pkg and vtnr_select.
`default_nettype none
module voxel_threshold_neighbor_replace
  import vtnr_pkg::*;
#(
  parameter int MAX_X = 128,
  parameter int MAX_Y = 128,
  parameter int MAX_Z = 128,
  parameter int VALUE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_beat_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_beat_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [ValueW-1:0] cfg_data
);
  localparam int VB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int Plane = MAX_X * MAX_Y;
  localparam int Depth = 2 * Plane + 1;
  localparam int AW = $clog2(Depth);
  localparam int XW = $clog2(MAX_X + 1);
  localparam int YW = $clog2(MAX_Y + 1);
  localparam int ZW = $clog2(MAX_Z + 1);
  localparam logic [CountW-1:0] CntMax = '1;

  // Configuration registers.
  logic signed [ValueW-1:0] threshold;
  logic                     compare_mode;
  logic [XW-1:0]            dim_x;
  logic [YW-1:0]            dim_y;
  logic [ZW-1:0]            dim_z;
  logic                     dim_write;

  function automatic logic [10:0] clamp(input logic [7:0] v, input int maxv);
    logic [10:0] r;
    r = {3'd0, v};
    if (v == 8'd0) r = 11'd1;
    else if (32'(v) > maxv) r = 11'(maxv);
    return r;
  endfunction

  assign dim_write = cfg_we && (cfg_index == REG_DIM_X || cfg_index == REG_DIM_Y ||
                                cfg_index == REG_DIM_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= '0;
      compare_mode <= 1'b0;
      dim_x        <= XW'(clamp(8'd128, MAX_X));
      dim_y        <= YW'(clamp(8'd128, MAX_Y));
      dim_z        <= ZW'(clamp(8'd128, MAX_Z));
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold <= ValueW'(signed'(cfg_data[VB-1:0]));
        REG_MODE:      compare_mode <= cfg_data[0];
        REG_DIM_X:     dim_x <= XW'(clamp(cfg_data[7:0], MAX_X));
        REG_DIM_Y:     dim_y <= YW'(clamp(cfg_data[7:0], MAX_Y));
        REG_DIM_Z:     dim_z <= ZW'(clamp(cfg_data[7:0], MAX_Z));
        default: ;
      endcase
    end
  end

  // Derived sizes, registered. The plane size is registered from the dimensions and the
  // volume size from the plane size, so the input is held off after reset or a dimension
  // write until both have settled.
  logic [CountW-1:0] plane_sz, total;
  always_ff @(posedge clk) begin
    plane_sz <= CountW'(dim_x * dim_y);
    total    <= CountW'(plane_sz * dim_z);
  end

  logic [1:0] settle;
  always_ff @(posedge clk) begin
    if (rst || dim_write) settle <= 2'd2;
    else if (settle != 2'd0) settle <= settle - 1'b1;
  end

  // Stage 0: counters and window write. The pipeline advances only when
  // the output side has room, so a stall holds every stage.
  logic advance;
  logic take;
  logic [CountW-1:0] received_count, emitted_count, flag_total;
  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [ZW-1:0] pl;
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic store, emit, last;

  assign in_ready = advance && (settle == 2'd0);
  assign take = in_valid && in_ready;
  assign store = in_valid && !in_data.req_type && (received_count < total);
  always_comb begin
    logic [CountW-1:0] rc;
    rc = received_count + CountW'(store);
    emit = in_valid && (emitted_count < rc) &&
           ((rc - emitted_count > plane_sz) || (rc >= total));
  end
  assign last = (emitted_count == total - 1'b1);

  // Window store, read at the centre and its six neighbours in one beat.
  // Each of the seven reads has its own copy of the store, all written alike.
  logic signed [ValueW-1:0] rd_q [7];
  logic [AW-1:0] rd_a [7];
  logic signed [ValueW-1:0] fwd;
  assign fwd = ValueW'(signed'(in_data.voxel_value[VB-1:0]));

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] p,
                                         input logic [CountW-1:0] off, input logic neg);
    logic [AW:0] s;
    if (neg) begin
      s = {1'b0, p} - (AW+1)'(off);
      if (s[AW]) s = s + (AW+1)'(Depth);
    end else begin
      s = {1'b0, p} + (AW+1)'(off);
      if (s >= (AW+1)'(Depth)) s = s - (AW+1)'(Depth);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    rd_a[0] = rd_ptr;
    rd_a[1] = wrap(rd_ptr, plane_sz, 1'b1);
    rd_a[2] = wrap(rd_ptr, CountW'(dim_x), 1'b1);
    rd_a[3] = wrap(rd_ptr, CountW'(1), 1'b1);
    rd_a[4] = wrap(rd_ptr, CountW'(1), 1'b0);
    rd_a[5] = wrap(rd_ptr, CountW'(dim_x), 1'b0);
    rd_a[6] = wrap(rd_ptr, plane_sz, 1'b0);
  end

  for (genvar g = 0; g < 7; g++) begin : g_win
    logic signed [ValueW-1:0] win [Depth];
    logic signed [ValueW-1:0] q;
    always_ff @(posedge clk) begin
      if (take && store) win[wr_ptr] <= fwd;
      if (advance) q <= win[rd_a[g]];
    end
    assign rd_q[g] = q;
  end

  // Edge flags for the seven reads, carried alongside.
  logic [6:0] edge_ok;
  assign edge_ok = {pl != dim_z - 1'b1, row != dim_y - 1'b1, col != dim_x - 1'b1,
                    col != '0, row != '0, pl != '0, 1'b1};

  always_ff @(posedge clk) begin
    if (rst || (dim_write && !advance)) begin
      received_count <= '0; emitted_count <= '0;
      wr_ptr <= '0; rd_ptr <= '0; col <= '0; row <= '0; pl <= '0;
    end else if (dim_write) begin
      received_count <= '0; emitted_count <= '0;
      wr_ptr <= '0; rd_ptr <= '0; col <= '0; row <= '0; pl <= '0;
    end else if (take) begin
      if (emit && last) begin
        received_count <= '0; emitted_count <= '0;
        wr_ptr <= '0; rd_ptr <= '0; col <= '0; row <= '0; pl <= '0;
      end else begin
        if (store) begin
          received_count <= received_count + 1'b1;
          wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
        end
        if (emit) begin
          emitted_count <= emitted_count + 1'b1;
          rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
          if (col == dim_x - 1'b1) begin
            col <= '0;
            if (row == dim_y - 1'b1) begin
              row <= '0; pl <= pl + 1'b1;
            end else begin
              row <= row + 1'b1;
            end
          end else begin
            col <= col + 1'b1;
          end
        end
      end
    end
  end

  // Stage 1: registered window reads. The window write happens at the same
  // edge, and a read can hit the entry being written this beat, most often
  // the +z neighbour just stored; those reads take the incoming value.
  logic s1_valid, s1_last;
  logic [6:0] s1_ok;
  logic [6:0] s1_hit;
  logic signed [ValueW-1:0] s1_fwd;
  logic signed [ValueW-1:0] s1_v [7];
  always_ff @(posedge clk) begin
    if (rst || dim_write) s1_valid <= 1'b0;
    else if (advance) s1_valid <= take && emit;
    if (advance) begin
      for (int i = 0; i < 7; i++)
        s1_hit[i] <= store && (rd_a[i] == wr_ptr);
      s1_fwd  <= fwd;
      s1_ok   <= edge_ok;
      s1_last <= last;
    end
  end

  always_comb begin
    for (int i = 0; i < 7; i++)
      s1_v[i] = s1_hit[i] ? s1_fwd : rd_q[i];
  end

  // Stages 2 and 3: selection unit.
  out_beat_t sel_data;
  logic sel_valid;
  logic flagged_hit;
  vtnr_select u_sel (
    .clk, .rst, .advance,
    .in_valid(s1_valid), .vals(s1_v), .ok(s1_ok), .last(s1_last),
    .threshold, .compare_mode, .flag_total,
    .out_valid(sel_valid), .out_data(sel_data), .flagged(flagged_hit)
  );

  // Running flag count, updated as each centre leaves selection.
  always_ff @(posedge clk) begin
    if (rst || dim_write) flag_total <= '0;
    else if (advance && sel_valid) begin
      if (sel_data.last_voxel) flag_total <= '0;
      else if (flagged_hit && flag_total != CntMax) flag_total <= flag_total + 1'b1;
    end
  end

  // Output register; the whole pipe advances when it is free or drained.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= sel_valid;
    if (advance) out_data <= sel_data;
  end
  assign advance = !out_valid || out_ready;
endmodule
`default_nettype wire

// ===== sv/vtnr_select.sv =====
// Neighbour selection for the voxel replacement block: a registered first half, then a combinational second half.
// Depends on vtnr_pkg.
`default_nettype none
module vtnr_select
  import vtnr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     advance,
  input  wire logic                     in_valid,
  input  wire logic signed [ValueW-1:0] vals [7],
  input  wire logic [6:0]               ok,
  input  wire logic                     last,
  input  wire logic signed [ValueW-1:0] threshold,
  input  wire logic                     compare_mode,
  input  wire logic [CountW-1:0]        flag_total,
  output logic                          out_valid,
  output out_beat_t                     out_data,
  output logic                          flagged
);
  localparam logic [CountW-1:0] CntMax = '1;
  // First half: -z, -y, -x against the centre.
  logic a_valid, a_last, a_flag;
  logic [6:0] a_ok;
  logic signed [ValueW-1:0] a_best;
  logic [DirW-1:0] a_dir;
  logic signed [ValueW-1:0] a_v [4:6];
  logic signed [ValueW-1:0] a_best_n;
  logic [DirW-1:0] a_dir_n;
  logic a_flag_n;

  function automatic logic beats(input logic signed [ValueW-1:0] n, b, t,
                                 input logic m);
    return m ? (n <= t && n < b) : (n >= t && n > b);
  endfunction

  always_comb begin
    logic signed [ValueW-1:0] b;
    logic [DirW-1:0] d;
    logic f;
    b = vals[0]; d = DIR_NONE;
    f = compare_mode ? (vals[0] > threshold) : (vals[0] < threshold);
    for (int i = 1; i <= 3; i++)
      if (f && ok[i] && beats(vals[i], b, threshold, compare_mode)) begin
        b = vals[i]; d = DirW'(i);
      end
    a_best_n = b; a_dir_n = d; a_flag_n = f;
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (advance) a_valid <= in_valid;
    if (advance) begin
      a_best <= a_best_n; a_dir <= a_dir_n; a_flag <= a_flag_n;
      a_ok <= ok; a_last <= last;
      for (int i = 4; i <= 6; i++) a_v[i] <= vals[i];
    end
  end

  // Second half: +x, +y, +z.
  always_comb begin
    logic signed [ValueW-1:0] b;
    logic [DirW-1:0] d;
    b = a_best; d = a_dir;
    for (int i = 4; i <= 6; i++)
      if (a_flag && a_ok[i] && beats(a_v[i], b, threshold, compare_mode)) begin
        b = a_v[i]; d = DirW'(i);
      end
    out_data.new_value = b;
    out_data.source_dir = d;
    out_data.was_flagged = a_flag;
    out_data.flagged_count = (a_flag && flag_total != CntMax) ? flag_total + 1'b1
                                                              : flag_total;
    out_data.last_voxel = a_last;
  end
  assign out_valid = a_valid;
  assign flagged = a_flag;
endmodule
`default_nettype wire

// ===== sv/vtnr_checker.sv =====
// Port-level checker for the voxel replacement block, bound to the top level.
// Depends on vtnr_pkg.
`default_nettype none
module vtnr_checker
  import vtnr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");
  a_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.was_flagged |-> out_data.source_dir == DIR_NONE)
    else $error("unflagged centre reports a source");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.source_dir <= DIR_PZ)
    else $error("source direction out of range");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input beat taken while the output is stalled");
endmodule

bind voxel_threshold_neighbor_replace vtnr_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

// ===== tb/sv/voxel_threshold_neighbor_replace_test.sv =====
// Self-checking testbench for the voxel threshold neighbour replacement block.
// Holds a predictor of the streamed window replacement and a result scoreboard.
// Depends on vtnr_pkg and voxel_threshold_neighbor_replace.
`default_nettype none
module voxel_threshold_neighbor_replace_test;
  import vtnr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxDim = 128;
  localparam int WinDepth = 2 * MaxDim * MaxDim + 1;
  localparam int CntMax = 4194303;
  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 8;

  localparam logic ReqVoxel = 1'b0;
  localparam logic ReqFlush = 1'b1;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  out_beat_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [ValueW-1:0] cfg_data;

  voxel_threshold_neighbor_replace u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the block's registers and counters.
  logic signed [31:0] win_mem [WinDepth];
  int unsigned rx_cnt, tx_cnt, flag_cnt;
  logic signed [31:0] thr;
  logic gt_mode;
  int unsigned nx, ny, nz;

  out_beat_t pending_results[$];
  int errors;
  int unsigned cycle_cnt;
  int unsigned results_seen;
  int unsigned flagged_seen;
  int unsigned replaced_seen;
  int unsigned volumes_done;

  // Receiver behaviour: rx_idle_pct out of 100, plus a cycle-counted hold-off.
  int unsigned rx_idle_pct;
  int unsigned rx_hold;
  int unsigned tx_idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clamp_size(logic [31:0] v);
    logic [7:0] b;
    b = v[7:0];
    if (b == 8'd0) return 1;
    if (b > MaxDim) return MaxDim;
    return b;
  endfunction

  function automatic logic better(logic signed [31:0] n, logic signed [31:0] best);
    if (gt_mode) return n <= thr && n < best;
    return n >= thr && n > best;
  endfunction

  function automatic logic signed [31:0] win_at(int unsigned idx);
    return win_mem[idx % WinDepth];
  endfunction

  // Advances the predictor by one accepted beat; returns 1 when a result is due.
  function automatic logic predict_replacement(in_beat_t beat, output out_beat_t res);
    int unsigned plane, total, c, col, row, pl;
    logic signed [31:0] best, nb;
    dir_t dir;
    logic flagged;
    plane = nx * ny;
    total = plane * nz;
    res = '0;
    if (beat.req_type == ReqVoxel && rx_cnt < total) begin
      win_mem[rx_cnt % WinDepth] = beat.voxel_value;
      rx_cnt++;
    end
    if (!(tx_cnt < rx_cnt && (rx_cnt - tx_cnt > plane || rx_cnt >= total))) return 1'b0;
    c = tx_cnt;
    col = c % nx;
    row = (c / nx) % ny;
    pl = c / plane;
    best = win_at(c);
    dir = DIR_NONE;
    flagged = gt_mode ? (best > thr) : (best < thr);
    if (flagged) begin
      if (flag_cnt < CntMax) flag_cnt++;
      if (pl != 0) begin
        nb = win_at(c - plane);
        if (better(nb, best)) begin best = nb; dir = DIR_MZ; end
      end
      if (row != 0) begin
        nb = win_at(c - nx);
        if (better(nb, best)) begin best = nb; dir = DIR_MY; end
      end
      if (col != 0) begin
        nb = win_at(c - 1);
        if (better(nb, best)) begin best = nb; dir = DIR_MX; end
      end
      if (col != nx - 1) begin
        nb = win_at(c + 1);
        if (better(nb, best)) begin best = nb; dir = DIR_PX; end
      end
      if (row != ny - 1) begin
        nb = win_at(c + nx);
        if (better(nb, best)) begin best = nb; dir = DIR_PY; end
      end
      if (pl != nz - 1) begin
        nb = win_at(c + plane);
        if (better(nb, best)) begin best = nb; dir = DIR_PZ; end
      end
    end
    res.new_value = best;
    res.source_dir = dir;
    res.was_flagged = flagged;
    res.flagged_count = flag_cnt[CountW-1:0];
    res.last_voxel = (c == total - 1);
    tx_cnt++;
    if (c == total - 1) begin
      rx_cnt = 0;
      tx_cnt = 0;
      flag_cnt = 0;
    end
    return 1'b1;
  endfunction

  // Cycle counter doubling as the run watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("[voxel_threshold_neighbor_replace] ERROR");
      $finish;
    end
  end

  // Receiver: random idling, plus a long hold-off counted down here.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker: each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result beat: actual %h", $time, out_data);
        errors++;
      end else begin
        exp_beat = pending_results.pop_front();
        results_seen++;
        if (exp_beat.was_flagged) flagged_seen++;
        if (exp_beat.source_dir != DIR_NONE) replaced_seen++;
        if (exp_beat.last_voxel) volumes_done++;
        if (out_data.new_value !== exp_beat.new_value) begin
          $display("%0t new_value mismatch: expected %h actual %h", $time,
                   exp_beat.new_value, out_data.new_value);
          errors++;
        end
        if (out_data.source_dir !== exp_beat.source_dir) begin
          $display("%0t source_dir mismatch: expected %0d actual %0d", $time,
                   exp_beat.source_dir, out_data.source_dir);
          errors++;
        end
        if (out_data.was_flagged !== exp_beat.was_flagged) begin
          $display("%0t was_flagged mismatch: expected %b actual %b", $time,
                   exp_beat.was_flagged, out_data.was_flagged);
          errors++;
        end
        if (out_data.flagged_count !== exp_beat.flagged_count) begin
          $display("%0t flagged_count mismatch: expected %0d actual %0d", $time,
                   exp_beat.flagged_count, out_data.flagged_count);
          errors++;
        end
        if (out_data.last_voxel !== exp_beat.last_voxel) begin
          $display("%0t last_voxel mismatch: expected %b actual %b", $time,
                   exp_beat.last_voxel, out_data.last_voxel);
          errors++;
        end
      end
    end
  end

  // Sends one beat: random idling first, then hold valid until it is taken.
  // The prediction is made at acceptance so the queue always leads the block.
  // Valid stays high afterwards; the next beat or a drain takes it down.
  task automatic send_beat(logic kind, logic [31:0] value);
    out_beat_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: kind, voxel_value: value};
    do @(posedge clk); while (!in_ready);
    if (predict_replacement('{req_type: kind, voxel_value: value}, res))
      pending_results.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write; only issued once the block has no work left.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr = value;
      REG_MODE: gt_mode = value[0];
      REG_DIM_X: begin nx = clamp_size(value); rx_cnt = 0; tx_cnt = 0; flag_cnt = 0; end
      REG_DIM_Y: begin ny = clamp_size(value); rx_cnt = 0; tx_cnt = 0; flag_cnt = 0; end
      REG_DIM_Z: begin nz = clamp_size(value); rx_cnt = 0; tx_cnt = 0; flag_cnt = 0; end
      default: ;
    endcase
  endtask

  task automatic set_volume(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    write_reg(REG_DIM_X, x);
    write_reg(REG_DIM_Y, y);
    write_reg(REG_DIM_Z, z);
  endtask

  // Random voxel value, biased towards the threshold and towards ties.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return thr;
      2: return thr + $urandom_range(3) - 1;
      3: return 32'h8000_0000 | $urandom_range(1);
      4: return 32'h7FFF_FFFF - $urandom_range(1);
      default: return thr + $urandom_range(2000) - 1000;
    endcase
  endfunction

  // Streams a whole volume then flushes out its tail.
  task automatic send_volume(int unsigned flush_gaps);
    int unsigned total;
    total = nx * ny * nz;
    for (int unsigned i = 0; i < total; i++) begin
      send_beat(ReqVoxel, pick_value());
      if (flush_gaps != 0 && $urandom_range(99) < flush_gaps) send_beat(ReqFlush, $urandom);
    end
    while (rx_cnt != 0) send_beat(($urandom_range(3) == 0) ? ReqVoxel : ReqFlush, $urandom);
  endtask

  logic [31:0] dir_vals [8] = '{32'h5, 32'hFFFF_FFF0, 32'hFFFF_FFF8, 32'h3,
                                32'hFFFF_FFF4, 32'h7, 32'h1, 32'h8000_0000};

  // Directed: the smallest volume, dimension zero, extremes of value and threshold.
  task automatic test_directed_corners();
    set_volume(0, 0, 0);
    write_reg(REG_THRESHOLD, 32'h7FFF_FFFF);
    send_beat(ReqVoxel, 32'h8000_0000);
    send_beat(ReqFlush, 32'h0);
    write_reg(REG_MODE, 1);
    write_reg(REG_THRESHOLD, 32'h8000_0000);
    send_beat(ReqVoxel, 32'h7FFF_FFFF);
    // 3x1x1 line: centre fails, two neighbours tie so the first one wins.
    write_reg(REG_MODE, 0);
    write_reg(REG_THRESHOLD, 32'h0001_0000);
    set_volume(3, 1, 1);
    send_beat(ReqFlush, 32'h0);
    send_beat(ReqVoxel, 32'h0002_0000);
    send_beat(ReqVoxel, 32'hFFFF_0000);
    send_beat(ReqVoxel, 32'h0002_0000);
    send_beat(ReqVoxel, 32'h1234_5678);
    send_beat(ReqFlush, 32'h0);
    // 2x2x2 cube, greater-than mode, with every direction reachable.
    write_reg(REG_MODE, 1);
    write_reg(REG_THRESHOLD, 32'h0);
    set_volume(2, 2, 2);
    foreach (dir_vals[i]) send_beat(ReqVoxel, dir_vals[i]);
    send_beat(ReqFlush, 32'h0);
    send_beat(ReqFlush, 32'h0);
    // Oversized dimension saturates; abandoned partial volume then rewritten.
    set_volume(200, 1, 1);
    for (int i = 0; i < 3; i++) send_beat(ReqVoxel, $urandom);
  endtask

  // Random volumes of small shapes and both modes, with flushes mixed in.
  task automatic test_random_volumes(int unsigned beats);
    int unsigned sent;
    sent = 0;
    while (sent < beats) begin
      write_reg(REG_THRESHOLD, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000) - 1000);
      write_reg(REG_MODE, $urandom_range(1));
      set_volume($urandom_range(6), $urandom_range(5), $urandom_range(4));
      send_volume($urandom_range(1) ? 10 : 0);
      sent += nx * ny * nz;
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    set_volume(8, 4, 3);
    rx_hold = 300;
    send_volume(0);
    wait_drained();
  endtask

  // A stretch with no idling on either side.
  task automatic test_full_rate();
    rx_idle_pct = 0;
    tx_idle_pct = 0;
    set_volume(5, 4, 3);
    send_volume(0);
    rx_idle_pct = 13;
    tx_idle_pct = 13;
  endtask

  // Widest line with one row and one layer, at threshold zero in less-than mode.
  task automatic test_wide_plane();
    write_reg(REG_MODE, 0);
    write_reg(REG_THRESHOLD, 32'h0);
    set_volume(128, 1, 1);
    send_volume(0);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data = '0;
    errors = 0;
    cycle_cnt = 0;
    results_seen = 0;
    flagged_seen = 0;
    replaced_seen = 0;
    volumes_done = 0;
    rx_idle_pct = 13;
    tx_idle_pct = 13;
    rx_hold = 0;
    rx_cnt = 0;
    tx_cnt = 0;
    flag_cnt = 0;
    thr = 0;
    gt_mode = 1'b0;
    nx = MaxDim;
    ny = MaxDim;
    nz = MaxDim;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();
    test_full_rate();
    test_backpressure();
    test_wide_plane();
    test_random_volumes(160);
    wait_drained();

    $display("Covered %0d results over %0d volumes: %0d flagged, %0d replaced.",
             results_seen, volumes_done, flagged_seen, replaced_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[voxel_threshold_neighbor_replace] OK");
    end else begin
      $display("%0t %0d mismatches, %0d results never arrived", $time, errors,
               pending_results.size());
      $display("[voxel_threshold_neighbor_replace] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
